[hdl/assert_macros.svh]
// Assertion macros shared by the sorted priority queue RTL.
// Expects clk and rst_n to be visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger implies the consequence in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

[hdl/spq_pkg.sv]
// Package for the sorted priority queue: sizes, command and status codes,
// and the per-cell control struct. No dependencies.
`default_nettype none

package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/spq_cell.sv]
// One storage cell of the sorted queue chain: holds a key and payload,
// shifts right on insert, left on removal. Depends on spq_pkg.
`default_nettype none

module spq_cell (
    input  wire logic                        clk,
    input  wire spq_pkg::cell_ctrl_t         ctrl,
    input  wire logic                        occupied,
    input  wire logic [spq_pkg::KEY_W-1:0]   new_key,
    input  wire logic [spq_pkg::DATA_W-1:0]  new_payload,
    input  wire logic                        left_keep,
    input  wire logic [spq_pkg::KEY_W-1:0]   left_key,
    input  wire logic [spq_pkg::DATA_W-1:0]  left_payload,
    input  wire logic [spq_pkg::KEY_W-1:0]   right_key,
    input  wire logic [spq_pkg::DATA_W-1:0]  right_payload,
    output logic                             keep,
    output logic [spq_pkg::KEY_W-1:0]        cell_key,
    output logic [spq_pkg::DATA_W-1:0]       cell_payload
);

    logic [spq_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [spq_pkg::DATA_W-1:0] payload_reg, payload_next;

    // entry stays put on insert when its key is not larger than the new one
    assign keep = occupied && (key_reg <= new_key);

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctrl.ins)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    key_next     = new_key;
                    payload_next = new_payload;
                end
                else
                begin
                    key_next     = left_key;
                    payload_next = left_payload;
                end
            end
        end
        else if (ctrl.del)
        begin
            key_next     = right_key;
            payload_next = right_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign cell_key     = key_reg;
    assign cell_payload = payload_reg;

endmodule

`default_nettype wire

[hdl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: chain of spq_cell, entry count,
// result register. Depends on spq_pkg, spq_cell and assert_macros.svh.
//
//  channel | valid     | stall     | fields
//  --------+-----------+-----------+--------------------------------------------
//  in      | in_valid  | in_stall  | command, key, payload
//  out     | out_valid | out_stall | status, front_valid, front_key,
//          |           |           | front_payload, entry_count
//
// Each transfer is applied to all cells together; its result appears in
// the result register the following cycle, so one item per cycle is
// sustained while in_stall is low. in_stall is high only while a result is
// held and out_stall is high. Reset clears the internal entry count and the
// result valid; cell contents are unused until written.
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          command,
    input  wire logic [spq_pkg::KEY_W-1:0]     key,
    input  wire logic [spq_pkg::DATA_W-1:0]    payload,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [spq_pkg::STAT_W-1:0]         status,
    output logic                               front_valid,
    output logic [spq_pkg::KEY_W-1:0]          front_key,
    output logic [spq_pkg::DATA_W-1:0]         front_payload,
    output logic [spq_pkg::CNT_W-1:0]          entry_count
);

    localparam int D = spq_pkg::DEPTH;

    logic [spq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       out_valid_reg;
    logic [spq_pkg::STAT_W-1:0] status_reg;
    logic                       front_valid_reg;
    logic [spq_pkg::KEY_W-1:0]  front_key_reg;
    logic [spq_pkg::DATA_W-1:0] front_payload_reg;
    logic [spq_pkg::CNT_W-1:0]  entry_count_reg;

    logic [spq_pkg::KEY_W-1:0]  cell_key     [D];
    logic [spq_pkg::DATA_W-1:0] cell_payload [D];
    logic [D-1:0]               keep;

    spq_pkg::cell_ctrl_t        ctrl;
    logic                       in_fire, is_enq, full, empty;
    logic [spq_pkg::STAT_W-1:0] status_next;
    logic [spq_pkg::KEY_W-1:0]  fkey_next;
    logic [spq_pkg::DATA_W-1:0] fpay_next;
    logic                       front_flag_ok, front_pair_ok;

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign is_enq   = (command == spq_pkg::CMD_ENQ);
    assign full     = (count_reg == spq_pkg::CNT_W'(D));
    assign empty    = (count_reg == '0);

    assign ctrl = '{ins: in_fire && is_enq && !full,
                    del: in_fire && !is_enq && !empty};

    genvar i;
    generate
        for (i = 0; i < D; i++)
        begin : g_cell
            logic                        occ;
            logic                        lk;
            logic [spq_pkg::KEY_W-1:0]   lkey, rkey;
            logic [spq_pkg::DATA_W-1:0]  lpay, rpay;

            assign occ = (count_reg > spq_pkg::CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign lk   = 1'b1;
                assign lkey = key;
                assign lpay = payload;
            end
            else
            begin : g_mid
                assign lk   = keep[i-1];
                assign lkey = cell_key[i-1];
                assign lpay = cell_payload[i-1];
            end

            if (i == D - 1)
            begin : g_last
                assign rkey = cell_key[i];
                assign rpay = cell_payload[i];
            end
            else
            begin : g_inner
                assign rkey = cell_key[i+1];
                assign rpay = cell_payload[i+1];
            end

            spq_cell u_cell (
                .clk           (clk),
                .ctrl          (ctrl),
                .occupied      (occ),
                .new_key       (key),
                .new_payload   (payload),
                .left_keep     (lk),
                .left_key      (lkey),
                .left_payload  (lpay),
                .right_key     (rkey),
                .right_payload (rpay),
                .keep          (keep[i]),
                .cell_key      (cell_key[i]),
                .cell_payload  (cell_payload[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = spq_pkg::ST_DONE;
        fkey_next   = '0;
        fpay_next   = '0;
        if (is_enq)
        begin
            if (full)
            begin
                status_next = spq_pkg::ST_FULL;
                fkey_next   = cell_key[0];
                fpay_next   = cell_payload[0];
            end
            else
            begin
                count_next = count_reg + 1'b1;
                if (empty || (key < cell_key[0]))
                begin
                    fkey_next = key;
                    fpay_next = payload;
                end
                else
                begin
                    fkey_next = cell_key[0];
                    fpay_next = cell_payload[0];
                end
            end
        end
        else
        begin
            if (empty)
                status_next = spq_pkg::ST_EMPTY;
            else
            begin
                count_next = count_reg - 1'b1;
                if (count_reg > spq_pkg::CNT_W'(1))
                begin
                    fkey_next = cell_key[1];
                    fpay_next = cell_payload[1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg        <= status_next;
            front_valid_reg   <= (count_next != '0);
            front_key_reg     <= fkey_next;
            front_payload_reg <= fpay_next;
            entry_count_reg   <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign front_valid   = front_valid_reg;
    assign front_key     = front_key_reg;
    assign front_payload = front_payload_reg;
    assign entry_count   = entry_count_reg;

    assign front_flag_ok = !out_valid_reg || (front_valid_reg == (entry_count_reg != '0));
    assign front_pair_ok = (count_reg < spq_pkg::CNT_W'(2)) || (cell_key[0] <= cell_key[1]);

    `SPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= spq_pkg::CNT_W'(D), "count exceeds depth")
    `SPQ_ASSERT_NEXT(a_enq_count, ctrl.ins, count_reg == $past(count_reg) + 1'b1, "enqueue count")
    `SPQ_ASSERT_ALWAYS(a_front_valid, front_flag_ok, "front_valid mismatch")
    `SPQ_ASSERT_ALWAYS(a_sorted, front_pair_ok, "front pair out of order")

endmodule

`default_nettype wire
